@@ src/tccw_pkg.sv @@
// Shared constants and types for the text console character writer.
// No dependencies.
`timescale 1ns / 1ps

package tccw_pkg;

  localparam int ROW_WIDTH = 80;

  localparam int COL_W   = 7;
  localparam int ROW_W   = 8;
  localparam int IDX_W   = 15;
  localparam int NUM_W   = 32;
  localparam int CHAR_W  = 8;
  localparam int DIGIT_W = 4;
  localparam int MAX_DIGITS = 10;
  localparam int DCNT_W  = 4;

  localparam logic [7:0] ATTR_WHITE_ON_BLACK = 8'h0F;
  localparam logic [7:0] ASCII_ZERO          = 8'd48;
  localparam logic [7:0] ROW_LAST            = 8'hFF;

  // floor(n / 10) == (n * RECIP10) >> RECIP10_SHIFT for all 32-bit n
  localparam logic [NUM_W-1:0] RECIP10       = 32'hCCCC_CCCD;
  localparam int               RECIP10_SHIFT = 35;

  localparam logic OP_CHAR   = 1'b0;
  localparam logic OP_NUMBER = 1'b1;

  typedef struct packed {
    logic [NUM_W-1:0]   quot;
    logic [DIGIT_W-1:0] rem;
  } div_res_t;

endpackage

@@ src/tccw_div10.sv @@
// Divide-by-ten unit: registered reciprocal multiply, then quotient and remainder.
// Depends on tccw_pkg.
`timescale 1ns / 1ps

module tccw_div10 (
  input  logic                          clk,
  input  logic                          load,
  input  logic [tccw_pkg::NUM_W-1:0]    dividend,
  output tccw_pkg::div_res_t            res
);

  logic [2*tccw_pkg::NUM_W-1:0] prod_r;
  logic [tccw_pkg::NUM_W-1:0]   dvd_r;
  logic [tccw_pkg::NUM_W-1:0]   quot;
  logic [tccw_pkg::NUM_W-1:0]   diff;

  always_ff @(posedge clk) begin
    if (load) begin
      prod_r <= dividend * tccw_pkg::RECIP10;
      dvd_r  <= dividend;
    end
  end

  assign quot = tccw_pkg::NUM_W'(prod_r >> tccw_pkg::RECIP10_SHIFT);
  // quot * 10 as two shifts
  assign diff = dvd_r - ((quot << 3) + (quot << 1));

  assign res.quot = quot;
  assign res.rem  = diff[tccw_pkg::DIGIT_W-1:0];

endmodule

@@ src/text_console_char_writer.sv @@
// Top level of the text console character writer: sequencer, digit store, cursor.
// Depends on tccw_pkg and tccw_div10.
`timescale 1ns / 1ps
//
// Input stream (in_*): one word is either a character (in_tuser = 0) or an
// unsigned 32-bit number printed in decimal (in_tuser = 1). in_tready is high
// only while the sequencer is idle; an item is taken when in_tvalid and
// in_tready are both high.
// Output stream (out_*): one word per printed character, carrying the cell
// address, the cell word (white on black) and the cursor location after the
// advance. out_tlast marks the final word of an item.
// Flow: a character goes from S_IDLE to S_EMIT, which loads it into the output
// register once that register is free. A number of D digits passes through the
// single divide-by-ten unit once per digit (S_MUL: one registered multiply by
// the reciprocal; S_DIV: the correction that stores the remainder digit), then
// emits one word per cycle while the output does not stall.
// The output register holds a word until out_tready; while it stalls the
// sequencer waits and the cursor does not move. A new item can be taken
// while the last word of the previous one is still waiting.
// Reset (rst_n low, synchronous) puts the cursor at cell 0 and drops
// out_tvalid.

module text_console_char_writer (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // char_code[7:0], number[39:8]
  input  logic        in_tuser,   // opcode
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,  // cell_address[14:0], cell_data[30:15],
                                  // cursor_location[45:31], zero pad[47:46]
  output logic        out_tlast
);

  typedef enum logic [1:0] {S_IDLE, S_MUL, S_DIV, S_EMIT} state_t;

  state_t state_r;

  logic [tccw_pkg::COL_W-1:0]   col_r;
  logic [tccw_pkg::ROW_W-1:0]   row_r;
  logic [tccw_pkg::IDX_W-1:0]   idx_r;
  logic [tccw_pkg::IDX_W-1:0]   idx_nxt;
  logic [tccw_pkg::COL_W-1:0]   col_nxt;
  logic [tccw_pkg::ROW_W-1:0]   row_nxt;

  logic                         chr_r;
  logic [tccw_pkg::CHAR_W-1:0]  char_r;
  logic [tccw_pkg::NUM_W-1:0]   num_r;
  logic [tccw_pkg::DCNT_W-1:0]  dcnt_r;
  logic [tccw_pkg::DIGIT_W-1:0] digits_r [tccw_pkg::MAX_DIGITS];

  logic                         out_tvalid_r;
  logic [tccw_pkg::IDX_W-1:0]   out_addr_r;
  logic [15:0]                  out_data_r;
  logic [tccw_pkg::IDX_W-1:0]   out_cur_r;
  logic                         out_last_r;

  tccw_pkg::div_res_t           div_res;
  logic                         in_fire;
  logic                         out_load;
  logic                         is_last;
  logic                         col_wrap;
  logic [tccw_pkg::DCNT_W-1:0]  rd_idx;
  logic [tccw_pkg::CHAR_W-1:0]  emit_code;

  tccw_div10 u_div10 (
    .clk      (clk),
    .load     (state_r == S_MUL),
    .dividend (num_r),
    .res      (div_res)
  );

  assign in_tready = (state_r == S_IDLE);
  assign in_fire   = in_tvalid && in_tready;
  assign out_load  = (state_r == S_EMIT) && (!out_tvalid_r || out_tready);

  assign rd_idx    = dcnt_r - tccw_pkg::DCNT_W'(1);
  assign is_last   = chr_r || (dcnt_r == tccw_pkg::DCNT_W'(1));
  assign emit_code = chr_r ? char_r
                           : (tccw_pkg::ASCII_ZERO | {4'b0, digits_r[rd_idx]});

  // cursor advance
  assign col_wrap = ({1'b0, col_r} + 8'd1) >= 8'(tccw_pkg::ROW_WIDTH);
  always_comb begin
    col_nxt = col_r + tccw_pkg::COL_W'(1);
    row_nxt = row_r;
    idx_nxt = idx_r + tccw_pkg::IDX_W'(1);
    if (col_wrap) begin
      col_nxt = '0;
      row_nxt = row_r + tccw_pkg::ROW_W'(1);
      if (row_r == tccw_pkg::ROW_LAST) begin
        idx_nxt = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      col_r        <= '0;
      row_r        <= '0;
      idx_r        <= '0;
      out_tvalid_r <= 1'b0;
      dcnt_r       <= '0;
      chr_r        <= 1'b0;
    end else begin
      if (out_tvalid_r && out_tready && !out_load) begin
        out_tvalid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_fire) begin
            char_r <= in_tdata[7:0];
            num_r  <= in_tdata[39:8];
            dcnt_r <= '0;
            if (in_tuser == tccw_pkg::OP_CHAR) begin
              chr_r   <= 1'b1;
              state_r <= S_EMIT;
            end else begin
              chr_r   <= 1'b0;
              state_r <= S_MUL;
            end
          end
        end
        S_MUL: begin
          state_r <= S_DIV;
        end
        S_DIV: begin
          digits_r[dcnt_r] <= div_res.rem;
          dcnt_r           <= dcnt_r + tccw_pkg::DCNT_W'(1);
          num_r            <= div_res.quot;
          if (div_res.quot == '0) begin
            state_r <= S_EMIT;
          end else begin
            state_r <= S_MUL;
          end
        end
        S_EMIT: begin
          if (out_load) begin
            out_tvalid_r <= 1'b1;
            out_addr_r   <= idx_r;
            out_data_r   <= {tccw_pkg::ATTR_WHITE_ON_BLACK, emit_code};
            out_cur_r    <= idx_nxt;
            out_last_r   <= is_last;
            col_r        <= col_nxt;
            row_r        <= row_nxt;
            idx_r        <= idx_nxt;
            dcnt_r       <= rd_idx;
            if (is_last) begin
              state_r <= S_IDLE;
            end
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {2'b00, out_cur_r, out_data_r, out_addr_r};
  assign out_tlast  = out_last_r;

endmodule

@@ src/tccw_checker.sv @@
// Port-level checks for the text console character writer, bound to the top level.
// Depends on text_console_char_writer.
`timescale 1ns / 1ps

module tccw_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [47:0] out_tdata,
  input logic        out_tlast
);

  logic in_fire;
  logic out_fire;

  assign in_fire  = in_tvalid && in_tready;
  assign out_fire = out_tvalid && out_tready;

  // no word left over from before reset
  a_reset_clears: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("out_tvalid high after reset");

  // busy after taking an item
  a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> !in_tready)
    else $error("in_tready high right after an accepted word");

  // no new item while a non-final word of the current one is on the output
  a_busy_mid_item: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tlast |-> !in_tready)
    else $error("input taken before the last output word");

  // stalled output word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("output word changed while stalled");

endmodule

bind text_console_char_writer tccw_checker u_tccw_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast)
);
